// File: rtl/clx_pkg.sv
// Package for the lexer: token and queue types, token kind codes,
// character constants, keyword tables and the byte classifier functions.
// Depends on nothing; used by every module of the block.
package clx_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int KIND_W      = 5;
    localparam int FIELD_W     = 16;
    localparam int NUM_KW      = 7;

    // pending run kinds
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_DASH = 2'd1;
    localparam logic [1:0] PEND_NUM  = 2'd2;
    localparam logic [1:0] PEND_WORD = 2'd3;

    // token kinds
    localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd0;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd1;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd2;
    localparam logic [KIND_W-1:0] K_CARET   = 5'd3;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd4;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd5;
    localparam logic [KIND_W-1:0] K_SLASH   = 5'd6;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd7;
    localparam logic [KIND_W-1:0] K_EQUAL   = 5'd8;
    localparam logic [KIND_W-1:0] K_GREATER = 5'd9;
    localparam logic [KIND_W-1:0] K_LESS    = 5'd10;
    localparam logic [KIND_W-1:0] K_ARROW   = 5'd11;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd12;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd13;
    localparam logic [KIND_W-1:0] K_LBRACE  = 5'd14;
    localparam logic [KIND_W-1:0] K_RBRACE  = 5'd15;
    localparam logic [KIND_W-1:0] K_HASH    = 5'd16;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd17;
    localparam logic [KIND_W-1:0] K_BOOLEAN = 5'd18;
    localparam logic [KIND_W-1:0] K_TYPE    = 5'd19;
    localparam logic [KIND_W-1:0] K_NAME    = 5'd20;
    localparam logic [KIND_W-1:0] K_END     = 5'd21;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [FIELD_W-1:0] LEN_MAX = {FIELD_W{1'b1}};
    localparam logic [NUM_KW-1:0]  KW_ALL  = {NUM_KW{1'b1}};

    // keywords: true, false, u32, r32, s32, struct, String
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
        '{"u", "3", "2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "3", "2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "3", "2", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "u", "c", "t", 8'h00, 8'h00},
        '{"S", "t", "r", "i", "n", "g", 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd6, 3'd6};
    localparam logic [NUM_KW-1:0] KW_BOOL_MASK = 7'b0000011;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               last;
    } t_token;

    // up to two tokens pushed into the output queue per byte, in order
    typedef struct packed {
        logic   valid0;
        logic   valid1;
        t_token tok0;
        t_token tok1;
    } t_push;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_numeric(logic [7:0] c);
        return is_digit(c) || (c == CH_DOT) || (c == CH_LO_F);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z))
            || (c == CH_UNDER);
    endfunction

    function automatic logic is_sep(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [KIND_W-1:0] punct_code(logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_CARET:  k = K_CARET;
            CH_PLUS:   k = K_PLUS;
            CH_SLASH:  k = K_SLASH;
            CH_STAR:   k = K_STAR;
            CH_EQUAL:  k = K_EQUAL;
            CH_GT:     k = K_GREATER;
            CH_LESS:   k = K_LESS;
            CH_COMMA:  k = K_COMMA;
            CH_SEMI:   k = K_SEMI;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_HASH:   k = K_HASH;
            default:   k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // keep a keyword flag only while the byte at this index still matches
    function automatic logic [NUM_KW-1:0] match_update(logic [NUM_KW-1:0] flags,
                                                       logic [FIELD_W-1:0] idx,
                                                       logic [7:0] c);
        logic [NUM_KW-1:0] r;
        r = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (flags[k] && (idx < FIELD_W'(KW_LEN[k])) && (KW_TEXT[k][idx[2:0]] == c)) begin
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [KIND_W-1:0] word_kind(logic [NUM_KW-1:0] flags,
                                                    logic [FIELD_W-1:0] len);
        logic [NUM_KW-1:0] hit;
        logic [KIND_W-1:0] k;
        hit = '0;
        for (int i = 0; i < NUM_KW; i++) begin
            hit[i] = flags[i] && (len == FIELD_W'(KW_LEN[i]));
        end
        if ((hit & KW_BOOL_MASK) != '0) begin
            k = K_BOOLEAN;
        end else if ((hit & ~KW_BOOL_MASK) != '0) begin
            k = K_TYPE;
        end else begin
            k = K_NAME;
        end
        return k;
    endfunction

endpackage

// File: rtl/clx_core.sv
// Lexer core: input word register, pending-run state and the token
// decision for one byte. Uses clx_pkg; feeds clx_outq with t_push.
module clx_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_text_byte,
    output logic                o_stall,
    input  logic                i_room,
    output clx_pkg::t_push      o_push
);

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic [1:0]                     r_kind;
    logic [clx_pkg::FIELD_W-1:0]    r_start;
    logic [clx_pkg::FIELD_W-1:0]    r_len;
    logic [clx_pkg::NUM_KW-1:0]     r_flags;
    logic [clx_pkg::OFFSET_BITS-1:0] r_pos;

    logic [1:0]                     n_kind;
    logic [clx_pkg::FIELD_W-1:0]    n_start;
    logic [clx_pkg::FIELD_W-1:0]    n_len;
    logic [clx_pkg::NUM_KW-1:0]     n_flags;
    logic [clx_pkg::OFFSET_BITS-1:0] n_pos;

    logic                           go;
    logic                           accept;
    logic                           fresh;
    logic                           va;
    logic                           vb;
    clx_pkg::t_token                tok_a;
    clx_pkg::t_token                tok_b;
    logic [7:0]                     c;
    logic [clx_pkg::FIELD_W-1:0]    pos16;
    logic [clx_pkg::FIELD_W-1:0]    len_inc;
    logic [clx_pkg::KIND_W-1:0]     pcode;

    assign go      = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;
    assign accept  = i_valid && !o_stall;

    assign c       = r_in_byte;
    assign pos16   = clx_pkg::FIELD_W'(r_pos);
    assign len_inc = (r_len == clx_pkg::LEN_MAX) ? r_len : r_len + 1'b1;
    assign pcode   = clx_pkg::punct_code(c);

    always_comb begin
        n_kind  = r_kind;
        n_start = r_start;
        n_len   = r_len;
        n_flags = r_flags;
        va      = 1'b0;
        vb      = 1'b0;
        fresh   = 1'b1;
        tok_a   = '{kind: clx_pkg::K_UNKNOWN, start: r_start, length: r_len, last: 1'b0};
        tok_b   = '{kind: clx_pkg::K_UNKNOWN, start: pos16, length: 16'd1, last: 1'b1};

        unique case (r_kind)
            clx_pkg::PEND_DASH: begin
                va           = 1'b1;
                tok_a.kind   = clx_pkg::K_MINUS;
                tok_a.length = 16'd1;
                if (c == clx_pkg::CH_GT) begin
                    tok_a.kind   = clx_pkg::K_ARROW;
                    tok_a.length = 16'd2;
                    fresh        = 1'b0;
                end
            end
            clx_pkg::PEND_NUM: begin
                if (clx_pkg::is_numeric(c)) begin
                    n_len = len_inc;
                    fresh = 1'b0;
                end else begin
                    va         = 1'b1;
                    tok_a.kind = clx_pkg::K_NUMBER;
                end
            end
            clx_pkg::PEND_WORD: begin
                if (clx_pkg::is_alpha(c) || clx_pkg::is_numeric(c)) begin
                    n_flags = clx_pkg::match_update(r_flags, r_len, c);
                    n_len   = len_inc;
                    fresh   = 1'b0;
                end else begin
                    va         = 1'b1;
                    tok_a.kind = clx_pkg::word_kind(r_flags, r_len);
                end
            end
            default: ;
        endcase

        // a flushed run clears the pending state
        if (va) begin
            n_kind  = clx_pkg::PEND_NONE;
            n_start = '0;
            n_len   = '0;
            n_flags = clx_pkg::KW_ALL;
        end

        if (fresh) begin
            if (c == clx_pkg::CH_NUL) begin
                vb         = 1'b1;
                tok_b.kind = clx_pkg::K_END;
            end else if (clx_pkg::is_sep(c)) begin
                vb = 1'b0;
            end else if (c == clx_pkg::CH_DASH) begin
                n_kind  = clx_pkg::PEND_DASH;
                n_start = pos16;
                n_len   = 16'd1;
            end else if (pcode != clx_pkg::K_UNKNOWN) begin
                vb         = 1'b1;
                tok_b.kind = pcode;
            end else if (clx_pkg::is_digit(c)) begin
                n_kind  = clx_pkg::PEND_NUM;
                n_start = pos16;
                n_len   = 16'd1;
            end else if (clx_pkg::is_alpha(c)) begin
                n_kind  = clx_pkg::PEND_WORD;
                n_start = pos16;
                n_len   = 16'd1;
                n_flags = clx_pkg::match_update(clx_pkg::KW_ALL, '0, c);
            end else begin
                vb = 1'b1;
            end
        end

        tok_a.last = !vb;
        n_pos      = (c == clx_pkg::CH_NUL) ? '0 : r_pos + 1'b1;
    end

    // compact the pair so the first token always sits in slot 0
    always_comb begin
        o_push.valid0 = go && (va || vb);
        o_push.valid1 = go && va && vb;
        o_push.tok0   = va ? tok_a : tok_b;
        o_push.tok1   = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_kind     <= clx_pkg::PEND_NONE;
            r_start    <= '0;
            r_len      <= '0;
            r_flags    <= clx_pkg::KW_ALL;
            r_pos      <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_kind  <= n_kind;
                r_start <= n_start;
                r_len   <= n_len;
                r_flags <= n_flags;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_text_byte;
        end
    end

endmodule

// File: rtl/clx_outq.sv
// Four-word output queue for tokens; takes up to two words a cycle and
// hands out one while i_stall is low. Uses clx_pkg types; written by clx_core.
module clx_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clx_pkg::t_push  i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_stall,
    output clx_pkg::t_token o_token
);

    clx_pkg::t_token r_mem [4];
    logic [1:0]      r_wptr;
    logic [1:0]      r_rptr;
    logic [2:0]      r_count;
    logic            pop;
    logic [1:0]      n_push;
    logic [1:0]      wptr_1;

    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_token = r_mem[r_rptr];
    assign pop     = o_valid && !i_stall;
    assign n_push  = {1'b0, i_push.valid0} + {1'b0, i_push.valid1};
    assign wptr_1  = r_wptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + n_push;
            r_rptr  <= r_rptr + {1'b0, pop};
            r_count <= r_count + {1'b0, n_push} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) begin
            r_mem[r_wptr] <= i_push.tok0;
        end
        if (i_push.valid1) begin
            r_mem[wptr_1] <= i_push.tok1;
        end
    end

endmodule

// File: rtl/c_like_token_lexer.sv
// Top level of the streaming lexer: clx_core makes tokens, clx_outq
// queues them. Depends on clx_pkg, clx_core and clx_outq.
//
// Usage:
//   Input channel: i_valid / o_stall with i_text_byte, one source byte per
//   word. A zero byte ends the text and restarts offsets at zero.
//   Output channel: o_valid / i_stall with token kind, start, length and
//   o_last_of_run, which marks the last token that one byte produced.
//   A byte is registered in the input word register; once the queue has
//   room it is decided and its tokens (zero, one or two) are written to
//   the token queue. One byte enters per cycle while o_stall is low; a
//   byte that ends a run and is itself a token gives two tokens. Tokens
//   leave one per cycle while i_stall is low, set by the single output port.
//   Runs (numbers, words, a dash) are held until the byte that ends them.
//   The core decides a byte only when the four-word token queue has room
//   for two words; a stalled receiver fills the queue and then holds off
//   the input through o_stall. Nothing is lost or dropped.
//   Reset (synchronous, active low) empties the queue and clears any
//   pending run and the offset counter.
module c_like_token_lexer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_text_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [clx_pkg::KIND_W-1:0]        o_token_kind,
    output logic [clx_pkg::FIELD_W-1:0]       o_token_start,
    output logic [clx_pkg::FIELD_W-1:0]       o_token_length,
    output logic                              o_last_of_run
);

    clx_pkg::t_push  push;
    clx_pkg::t_token head;
    logic            room;

    clx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .o_stall     (o_stall),
        .i_room      (room),
        .o_push      (push)
    );

    clx_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule

// File: rtl/clx_checker.sv
// Port-level checks for the lexer, attached to the top level by bind.
// Depends on clx_pkg and c_like_token_lexer.
module clx_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [clx_pkg::KIND_W-1:0]  o_token_kind,
    input logic [clx_pkg::FIELD_W-1:0] o_token_start,
    input logic [clx_pkg::FIELD_W-1:0] o_token_length,
    input logic                        o_last_of_run
);

    // a stalled word stays and keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_token_kind)
            && $stable(o_token_start) && $stable(o_token_length))
        else $error("stalled token changed");

    // the end token is always the last one its byte produces
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == clx_pkg::K_END) |-> o_last_of_run)
        else $error("end token not last of run");

    // every token covers at least one byte
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_token_length != '0))
        else $error("zero length token");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("token visible after reset");

    // an arrow always spans two bytes
    a_arrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_token_kind == clx_pkg::K_ARROW) |-> (o_token_length == 16'd2))
        else $error("arrow length wrong");

endmodule

bind c_like_token_lexer clx_checker u_clx_checker (.*);
